FILE: sv/irt_pkg.sv
package irt_pkg;

    localparam int ADDR_W = 64;
    localparam int TAG_W  = 8;
    localparam int HDL_W  = 8;
    localparam int OP_W   = 2;
    localparam int STAT_W = 3;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVERLAP    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_HANDLE = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd5;

    // one stored region, half-open [base, limit)
    typedef struct packed {
        logic [TAG_W-1:0]  kind;
        logic [TAG_W-1:0]  prot;
        logic [ADDR_W-1:0] limit;
        logic [ADDR_W-1:0] base;
    } region_t;

    localparam int REGION_W = $bits(region_t);

    // what the compare unit is asked to check
    typedef struct packed {
        logic              find_mode;
        logic [ADDR_W-1:0] key_lo;
        logic [ADDR_W-1:0] key_hi;
    } cmp_req_t;

endpackage

FILE: sv/interval_region_table.sv
// channel | direction | tuser               | tdata (lowest bit up)
// s_      | in        | operation[1:0]      | addr_start 64, addr_end 64, prot_in 8,
//         |           |                     | kind_in 8, slot_in 8 (152 bits)
// m_      | out       | status[2:0]         | slot_out 8, found_start 64, found_end 64,
//         |           |                     | found_prot 8, found_kind 8 (152 bits)
//
// insert and find walk every slot through one compare unit, one slot a cycle, set by the
// single read port of the slot ram: a successful insert, a find miss or a full pool walk all
// slots, a hit or an overlap stops at its slot
// remove reads only its own slot; empty ranges, out-of-range handles and unknown ops skip the walk
// after reset a clearing pass over every slot builds the free list; s_tready stays low
// one item at a time; a finished result waits in the output register, so the next
// item is taken while m_tvalid is held by a stalled m_tready
module interval_region_table import irt_pkg::*; #(
    parameter int SLOTS = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [1:0]    s_tuser,   // operation
    input  logic [151:0]  s_tdata,   // addr_start, addr_end, prot_in, kind_in, slot_in
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [2:0]    m_tuser,   // status
    output logic [151:0]  m_tdata    // slot_out, found_start, found_end, found_prot, found_kind
);

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam int ENT_W  = 1 + LINK_W + REGION_W;

    // sequencer
    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_LINK  = 8'b0000_1000,
        S_ALLOC = 8'b0001_0000,
        S_RMRD  = 8'b0010_0000,
        S_RMCHK = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // captured item
    logic [OP_W-1:0]   op_reg, op_next;
    logic [ADDR_W-1:0] key_a_reg, key_a_next;
    logic [ADDR_W-1:0] key_b_reg, key_b_next;
    logic [TAG_W-1:0]  prot_reg, prot_next;
    logic [TAG_W-1:0]  kind_reg, kind_next;
    logic [IDX_W-1:0]  handle_reg, handle_next;

    // scan / clear walk
    logic [LINK_W-1:0] scan_idx_reg, scan_idx_next;
    logic              data_v_reg, data_v_next;
    logic [IDX_W-1:0]  data_idx_reg, data_idx_next;

    // free list head; SLOTS means empty
    logic [LINK_W-1:0] free_head_reg, free_head_next;

    // finished result, waiting for the output register
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [HDL_W-1:0]  res_slot_reg, res_slot_next;
    region_t           res_region_reg, res_region_next;

    // output register
    logic              m_tvalid_reg, m_tvalid_next;
    logic              load_out;
    logic [STAT_W-1:0] out_status_reg;
    logic [HDL_W-1:0]  out_slot_reg;
    region_t           out_region_reg;

    // slot ram: {valid, free link, region}
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;

    logic              rd_valid;
    logic [LINK_W-1:0] rd_link;
    region_t           rd_region;

    cmp_req_t          cmp_req;
    logic              cmp_hit;

    // input field unpacking
    logic [ADDR_W-1:0] in_start;
    logic [ADDR_W-1:0] in_end;
    logic [TAG_W-1:0]  in_prot;
    logic [TAG_W-1:0]  in_kind;
    logic [HDL_W-1:0]  in_slot;

    assign in_start = s_tdata[63:0];
    assign in_end   = s_tdata[127:64];
    assign in_prot  = s_tdata[135:128];
    assign in_kind  = s_tdata[143:136];
    assign in_slot  = s_tdata[151:144];

    assign rd_valid  = ram_rdata[ENT_W-1];
    assign rd_link   = ram_rdata[ENT_W-2 -: LINK_W];
    assign rd_region = region_t'(ram_rdata[REGION_W-1:0]);

    irt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // the one compare unit, fed one slot per cycle during a scan
    assign cmp_req.find_mode = (op_reg == OP_FIND);
    assign cmp_req.key_lo    = key_a_reg;
    assign cmp_req.key_hi    = key_b_reg;

    irt_cmp u_cmp (
        .req         (cmp_req),
        .entry_valid (rd_valid),
        .entry       (rd_region),
        .hit         (cmp_hit)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_region_reg.kind, out_region_reg.prot, out_region_reg.limit,
                       out_region_reg.base, out_slot_reg};

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_a_next      = key_a_reg;
        key_b_next      = key_b_reg;
        prot_next       = prot_reg;
        kind_next       = kind_reg;
        handle_next     = handle_reg;
        scan_idx_next   = scan_idx_reg;
        data_v_next     = 1'b0;
        data_idx_next   = data_idx_reg;
        free_head_next  = free_head_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_region_next = res_region_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        load_out        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;

        unique case (state_reg)
            S_CLEAR: begin
                // slot i links to i + 1, nothing valid
                ram_we        = 1'b1;
                ram_waddr     = scan_idx_reg[IDX_W-1:0];
                ram_wdata     = {1'b0, scan_idx_reg + LINK_W'(1), {REGION_W{1'b0}}};
                scan_idx_next = scan_idx_reg + LINK_W'(1);
                if (scan_idx_reg == LINK_W'(SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_tuser;
                    key_a_next      = in_start;
                    key_b_next      = in_end;
                    prot_next       = in_prot;
                    kind_next       = in_kind;
                    handle_next     = IDX_W'(in_slot);
                    scan_idx_next   = '0;
                    res_slot_next   = '0;
                    res_region_next = '0;
                    unique case (s_tuser)
                        OP_INSERT: begin
                            if (in_start >= in_end) begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_FIND: begin
                            state_next = S_SCAN;
                        end
                        OP_REMOVE: begin
                            if (32'(in_slot) >= SLOTS) begin
                                res_status_next = ST_BAD_HANDLE;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_RMRD;
                            end
                        end
                        default: begin
                            // unknown operation
                            res_status_next = ST_BAD_HANDLE;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // issue one read a cycle; data for data_idx arrives in the cycle after its read
                ram_raddr = scan_idx_reg[IDX_W-1:0];
                if (scan_idx_reg < LINK_W'(SLOTS)) begin
                    scan_idx_next = scan_idx_reg + LINK_W'(1);
                    data_v_next   = 1'b1;
                    data_idx_next = scan_idx_reg[IDX_W-1:0];
                end
                if (data_v_reg && cmp_hit) begin
                    data_v_next     = 1'b0;
                    state_next      = S_DONE;
                    res_slot_next   = '0;
                    res_region_next = '0;
                    if (op_reg == OP_FIND) begin
                        res_status_next = ST_OK;
                        res_slot_next   = HDL_W'(data_idx_reg);
                        res_region_next = rd_region;
                    end else begin
                        res_status_next = ST_OVERLAP;
                    end
                end else if (data_v_reg && data_idx_reg == IDX_W'(SLOTS - 1)) begin
                    data_v_next     = 1'b0;
                    res_slot_next   = '0;
                    res_region_next = '0;
                    if (op_reg == OP_FIND) begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end else if (free_head_reg == LINK_W'(SLOTS)) begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end else begin
                        state_next = S_LINK;
                    end
                end
            end

            S_LINK: begin
                // fetch the link of the slot about to be taken
                ram_raddr  = free_head_reg[IDX_W-1:0];
                state_next = S_ALLOC;
            end

            S_ALLOC: begin
                ram_we          = 1'b1;
                ram_waddr       = free_head_reg[IDX_W-1:0];
                ram_wdata       = {1'b1, rd_link, kind_reg, prot_reg, key_b_reg, key_a_reg};
                free_head_next  = rd_link;
                res_status_next = ST_OK;
                res_slot_next   = HDL_W'(free_head_reg[IDX_W-1:0]);
                res_region_next = '0;
                state_next      = S_DONE;
            end

            S_RMRD: begin
                ram_raddr  = handle_reg;
                state_next = S_RMCHK;
            end

            S_RMCHK: begin
                res_slot_next   = '0;
                res_region_next = '0;
                state_next      = S_DONE;
                if (!rd_valid) begin
                    res_status_next = ST_BAD_HANDLE;
                end else begin
                    // freed slot goes to the head of the free list
                    ram_we          = 1'b1;
                    ram_waddr       = handle_reg;
                    ram_wdata       = {1'b0, free_head_reg, {REGION_W{1'b0}}};
                    free_head_next  = LINK_W'(handle_reg);
                    res_status_next = ST_OK;
                end
            end

            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    load_out      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            scan_idx_reg  <= '0;
            data_v_reg    <= 1'b0;
            free_head_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            data_v_reg    <= data_v_next;
            free_head_reg <= free_head_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_a_reg      <= key_a_next;
        key_b_reg      <= key_b_next;
        prot_reg       <= prot_next;
        kind_reg       <= kind_next;
        handle_reg     <= handle_next;
        data_idx_reg   <= data_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_region_reg <= res_region_next;
        if (load_out) begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_region_reg <= res_region_reg;
        end
    end

endmodule

FILE: sv/irt_ram.sv
module irt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/irt_cmp.sv
module irt_cmp import irt_pkg::*; (
    input  cmp_req_t req,
    input  logic     entry_valid,
    input  region_t  entry,
    output logic     hit
);

    logic lo_ok;
    logic hi_ok;

    // find: base <= addr; insert: base < new limit
    always_comb begin
        if (req.find_mode) begin
            lo_ok = entry.base <= req.key_lo;
        end else begin
            lo_ok = entry.base < req.key_hi;
        end
        hi_ok = req.key_lo < entry.limit;
        hit   = entry_valid && lo_ok && hi_ok;
    end

endmodule

FILE: dv/interval_region_table_test.sv
`timescale 1ns / 100ps

module interval_region_table_test;
    import irt_pkg::*;

    localparam int SLOTS         = 256;
    localparam int STALL_LIMIT   = 20000;   // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 300;     // about one full slot walk
    localparam int REPORT_MAX    = 10;

    // the block answers this code like a bad handle
    localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_MAX  = '1;

    // one answer of the table, in the order of m_tuser then m_tdata
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [HDL_W-1:0]  slot;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] limit;
        logic [TAG_W-1:0]  prot;
        logic [TAG_W-1:0]  kind;
    } table_reply_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser  = '0;    // operation
    logic [151:0] s_tdata  = '0;    // addr_start, addr_end, prot_in, kind_in, slot_in
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [2:0]   m_tuser;          // status
    logic [151:0] m_tdata;          // slot_out, found_start, found_end, found_prot, found_kind

    interval_region_table #(.SLOTS(SLOTS)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // shadow copy of the region table and its free list
    logic [ADDR_W-1:0] shadow_base  [SLOTS];
    logic [ADDR_W-1:0] shadow_limit [SLOTS];
    logic [TAG_W-1:0]  shadow_prot  [SLOTS];
    logic [TAG_W-1:0]  shadow_kind  [SLOTS];
    bit                shadow_used  [SLOTS];
    int                free_next    [SLOTS];
    int                free_top;

    table_reply_t      pending_replies [$];
    logic [ADDR_W-1:0] zone_base [4];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;
    int replies_checked = 0;
    int failures = 0;
    int idle_cycles = 0;
    int status_tally [8];

    initial begin
        forever #5 aclk = ~aclk;
    end

    // works out the answer to one request and updates the shadow table
    function automatic table_reply_t apply_request(
        input logic [OP_W-1:0]   op,
        input logic [ADDR_W-1:0] lo,
        input logic [ADDR_W-1:0] hi,
        input logic [TAG_W-1:0]  prot,
        input logic [TAG_W-1:0]  kind,
        input logic [HDL_W-1:0]  handle
    );
        table_reply_t r;
        int slot;
        int i;
        bit hit;
        r = '0;
        case (op)
            OP_INSERT: begin
                if (lo >= hi) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_OK;
                    for (i = 0; i < SLOTS; i++) begin
                        if (shadow_used[i] && shadow_base[i] < hi && lo < shadow_limit[i])
                            r.status = ST_OVERLAP;
                    end
                    if (r.status == ST_OK && free_top >= SLOTS)
                        r.status = ST_FULL;
                    if (r.status == ST_OK) begin
                        slot = free_top;
                        free_top = free_next[slot];
                        shadow_used[slot]  = 1'b1;
                        shadow_base[slot]  = lo;
                        shadow_limit[slot] = hi;
                        shadow_prot[slot]  = prot;
                        shadow_kind[slot]  = kind;
                        r.slot = slot[HDL_W-1:0];
                    end
                end
            end
            OP_FIND: begin
                r.status = ST_NOT_FOUND;
                hit = 1'b0;
                // lowest matching slot wins, though regions never overlap
                for (i = 0; i < SLOTS; i++) begin
                    if (!hit && shadow_used[i] && shadow_base[i] <= lo && lo < shadow_limit[i])
                    begin
                        hit = 1'b1;
                        r.status = ST_OK;
                        r.slot   = i[HDL_W-1:0];
                        r.base   = shadow_base[i];
                        r.limit  = shadow_limit[i];
                        r.prot   = shadow_prot[i];
                        r.kind   = shadow_kind[i];
                    end
                end
            end
            OP_REMOVE: begin
                if (int'(handle) >= SLOTS || !shadow_used[handle]) begin
                    r.status = ST_BAD_HANDLE;
                end else begin
                    shadow_used[handle] = 1'b0;
                    free_next[handle] = free_top;
                    free_top = int'(handle);
                    r.status = ST_OK;
                end
            end
            default: begin
                r.status = ST_BAD_HANDLE;
            end
        endcase
        status_tally[r.status]++;
        return r;
    endfunction

    // random live slot, or -1 on an empty table
    function automatic int pick_live_slot();
        int live [$];
        int i;
        for (i = 0; i < SLOTS; i++) begin
            if (shadow_used[i])
                live.push_back(i);
        end
        if (live.size() == 0)
            return -1;
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    // valid stays high after the accepting edge; idling in the next call or a drain lowers it
    task automatic send_request(
        input logic [OP_W-1:0]   op,
        input logic [ADDR_W-1:0] lo,
        input logic [ADDR_W-1:0] hi,
        input logic [TAG_W-1:0]  prot,
        input logic [TAG_W-1:0]  kind,
        input logic [HDL_W-1:0]  handle
    );
        // sender idles, each time with chance send_idle_pct, before raising valid
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {handle, kind, prot, hi, lo};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_replies.push_back(apply_request(op, lo, hi, prot, kind, handle));
        items_sent++;
    endtask

    // sender holds off until every answer is back
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic check_corner_cases();
        // empty table: plain miss, and nothing to remove
        send_request(OP_FIND, '0, ADDR_MAX, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_REMOVE, ADDR_MAX, ADDR_MAX, 8'h00, 8'h00, 8'h00);
        // zero-length and reversed ranges
        send_request(OP_INSERT, 64'h40, 64'h40, 8'h11, 8'h22, 8'h00);
        send_request(OP_INSERT, ADDR_MAX, '0, 8'hFF, 8'hFF, 8'hFF);
        // regions at the bottom and the top of the address space
        send_request(OP_INSERT, '0, 64'h10, 8'hFF, 8'h00, 8'hFF);
        send_request(OP_INSERT, ADDR_MAX - 64'hF, ADDR_MAX, 8'h00, 8'hFF, 8'h00);
        // partial and total overlap, then a region that only touches
        send_request(OP_INSERT, 64'h8, 64'h20, 8'h33, 8'h44, 8'h00);
        send_request(OP_INSERT, '0, ADDR_MAX, 8'h55, 8'h66, 8'h00);
        send_request(OP_INSERT, 64'h10, 64'h20, 8'h5A, 8'hA5, 8'h00);
        // lookups on both edges of each region
        send_request(OP_FIND, '0, '0, 8'h00, 8'h00, 8'h00);
        send_request(OP_FIND, 64'hF, '0, 8'h00, 8'h00, 8'h00);
        send_request(OP_FIND, 64'h10, '0, 8'h00, 8'h00, 8'h00);
        send_request(OP_FIND, 64'h20, '0, 8'h00, 8'h00, 8'h00);
        send_request(OP_FIND, ADDR_MAX - 64'hF, '0, 8'h00, 8'h00, 8'h00);
        send_request(OP_FIND, ADDR_MAX - 1, '0, 8'h00, 8'h00, 8'h00);
        send_request(OP_FIND, ADDR_MAX, ADDR_MAX, 8'hFF, 8'hFF, 8'hFF);
        // undefined operation
        send_request(OP_UNUSED, ADDR_MAX, ADDR_MAX, 8'hFF, 8'hFF, 8'hFF);
        // double remove, remove of a never used slot, lifo reuse
        send_request(OP_REMOVE, '0, '0, 8'h00, 8'h00, 8'd2);
        send_request(OP_REMOVE, '0, '0, 8'h00, 8'h00, 8'd2);
        send_request(OP_REMOVE, '0, '0, 8'h00, 8'h00, 8'hFF);
        send_request(OP_INSERT, 64'h100, 64'h200, 8'h0F, 8'hF0, 8'h00);
        send_request(OP_REMOVE, '0, '0, 8'h00, 8'h00, 8'd1);
        send_request(OP_REMOVE, '0, '0, 8'h00, 8'h00, 8'd0);
        send_request(OP_INSERT, 64'h200, 64'h300, 8'hC3, 8'h3C, 8'h00);
        send_request(OP_INSERT, 64'h1000, 64'h2000, 8'h96, 8'h69, 8'h00);
        drain_replies();
    endtask

    task automatic check_pool_exhaustion();
        logic [ADDR_W-1:0] fill_base;
        int n;
        int slot;
        fill_base = 64'h0000_1000_0000_0000;
        n = 0;
        // back-to-back regions until no slot is free
        while (free_top < SLOTS) begin
            send_request(OP_INSERT, fill_base + (64'(n) << 8), fill_base + (64'(n + 1) << 8),
                         8'($urandom), 8'($urandom), 8'($urandom));
            n++;
        end
        drain_replies();
        send_request(OP_INSERT, fill_base + (64'(n) << 8), fill_base + (64'(n + 1) << 8),
                     8'hAA, 8'h55, 8'h00);
        // overlap is reported ahead of a full pool
        send_request(OP_INSERT, fill_base, fill_base + 64'h1, 8'h00, 8'h00, 8'h00);
        send_request(OP_INSERT, fill_base, fill_base, 8'h00, 8'h00, 8'h00);
        send_request(OP_FIND, fill_base, '0, 8'h00, 8'h00, 8'h00);
        send_request(OP_FIND, fill_base + (64'(n) << 8) - 1, '0, 8'h00, 8'h00, 8'h00);
        send_request(OP_FIND, fill_base + (64'(n) << 8), '0, 8'h00, 8'h00, 8'h00);
        // empty it again in random order, which scrambles the free list
        slot = pick_live_slot();
        while (slot >= 0) begin
            send_request(OP_REMOVE, rand_addr(), rand_addr(), 8'h00, 8'h00, slot[HDL_W-1:0]);
            slot = pick_live_slot();
        end
        send_request(OP_REMOVE, '0, '0, 8'h00, 8'h00, 8'($urandom));
        drain_replies();
    endtask

    // mostly small regions packed into a few zones, so inserts both fit and collide
    task automatic run_random_traffic(input int count, input int send_pct, input int recv_pct);
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        int pick;
        int mode;
        int slot;
        int k;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) == 0)
                drain_replies();
            pick = $urandom_range(0, 99);
            mode = $urandom_range(0, 99);
            if (pick < 42) begin
                lo = zone_base[$urandom_range(0, 3)] + (64'($urandom_range(0, 1023)) << 4);
                if (mode < 85) begin
                    hi = lo + 64'($urandom_range(1, 48));
                end else if (mode < 92) begin
                    hi = lo - 64'($urandom_range(0, 3));
                end else begin
                    lo = rand_addr();
                    hi = rand_addr();
                end
                send_request(OP_INSERT, lo, hi, 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 80) begin
                slot = pick_live_slot();
                if (slot >= 0 && mode < 60) begin
                    lo = shadow_base[slot] + rand_addr() % (shadow_limit[slot] - shadow_base[slot]);
                end else if (slot >= 0 && mode < 70) begin
                    lo = shadow_limit[slot];
                end else if (mode < 90) begin
                    lo = zone_base[$urandom_range(0, 3)] + (64'($urandom_range(0, 1023)) << 4);
                end else begin
                    lo = rand_addr();
                end
                send_request(OP_FIND, lo, rand_addr(), 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 98) begin
                slot = pick_live_slot();
                if (slot < 0 || mode >= 75)
                    slot = $urandom_range(0, 255);
                send_request(OP_REMOVE, rand_addr(), rand_addr(), 8'($urandom), 8'($urandom),
                             slot[HDL_W-1:0]);
            end else begin
                send_request(OP_UNUSED, rand_addr(), rand_addr(), 8'($urandom), 8'($urandom),
                             8'($urandom));
            end
        end
        drain_replies();
    endtask

    // receiver stalls and result checking
    always @(posedge aclk) begin : reply_check
        table_reply_t want;
        table_reply_t got;
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tuser;
            got.slot   = m_tdata[7:0];
            got.base   = m_tdata[71:8];
            got.limit  = m_tdata[135:72];
            got.prot   = m_tdata[143:136];
            got.kind   = m_tdata[151:144];
            replies_checked++;
            if (pending_replies.size() == 0) begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("%0t: unexpected result status %0d slot %0d", $realtime,
                             got.status, got.slot);
            end else begin
                want = pending_replies.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.base !== want.base || got.limit !== want.limit ||
                    got.prot !== want.prot || got.kind !== want.kind) begin
                    failures++;
                    if (failures <= REPORT_MAX) begin
                        $display("%0t: result mismatch", $realtime);
                        $display("  expected status %0d slot %0d region %h..%h prot %h kind %h",
                                 want.status, want.slot, want.base, want.limit,
                                 want.prot, want.kind);
                        $display("  actual   status %0d slot %0d region %h..%h prot %h kind %h",
                                 got.status, got.slot, got.base, got.limit,
                                 got.prot, got.kind);
                    end
                end
            end
        end
    end

    // ends a hung run; the clearing pass after reset is far below the limit
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles with no handshake", STALL_LIMIT);
            $display("interval_region_table verification failed");
            $finish;
        end
    end

    initial begin : main_sequence
        int i;
        for (i = 0; i < SLOTS; i++) begin
            shadow_used[i] = 1'b0;
            free_next[i] = i + 1;
        end
        free_top = 0;
        for (i = 0; i < 8; i++)
            status_tally[i] = 0;
        // bottom and top of the address space plus two random zones
        zone_base[0] = '0;
        zone_base[1] = 64'hFFFF_FFFF_FFF0_0000;
        zone_base[2] = rand_addr() & ~64'hF_FFFF;
        zone_base[3] = rand_addr() & ~64'hF_FFFF;

        send_idle_pct = 8;
        recv_idle_pct = 69;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        check_corner_cases();
        check_pool_exhaustion();
        run_random_traffic(220, 8, 69);
        run_random_traffic(220, 69, 8);
        run_random_traffic(220, 0, 0);

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("ran %0d items and checked %0d results, pool filled and emptied once",
                 items_sent, replies_checked);
        $display("ok %0d, overlap %0d, pool full %0d, miss %0d, bad handle %0d, empty range %0d",
                 status_tally[ST_OK], status_tally[ST_OVERLAP], status_tally[ST_FULL],
                 status_tally[ST_NOT_FOUND], status_tally[ST_BAD_HANDLE],
                 status_tally[ST_EMPTY]);
        if (failures == 0) begin
            $display("interval_region_table verification clean");
        end else begin
            $display("%0d failing results", failures);
            $display("interval_region_table verification failed");
        end
        $finish;
    end

endmodule
